// ===== sv/sm3_pkg.sv =====
package sm3_pkg;

    // Word and block geometry
    localparam int WORD_W     = 32;
    localparam int BLOCK_WDS  = 16;
    localparam int DIGEST_WDS = 8;
    localparam int ROUNDS     = 64;
    localparam int LEN_W      = 64;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Full word byte count
    localparam logic [2:0] BYTES_FULL = 3'd4;

    // Padding word that opens the tail of a message
    localparam logic [WORD_W-1:0] PAD_WORD = 32'h8000_0000;

    // Round constants: low half, and the high half already rotated by 16
    localparam logic [WORD_W-1:0] T_LOW        = 32'h79cc_4519;
    localparam logic [WORD_W-1:0] T_HIGH_ROT16 = 32'h9d8a_7a87;

    localparam logic [WORD_W-1:0] SM3_IV [DIGEST_WDS] = '{
        32'h7380_166f, 32'h4914_b2b9, 32'h1724_42d7, 32'hda8a_0600,
        32'ha96f_30bc, 32'h1631_38aa, 32'he38d_ee4d, 32'hb0fb_0e4e
    };

    // One word on its way from the front to the back
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              final_wd;
    } t_qword;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                               input int unsigned n);
        return (x << n) | (x >> (WORD_W - n));
    endfunction

    function automatic logic [WORD_W-1:0] perm0(input logic [WORD_W-1:0] x);
        return x ^ rotl(x, 9) ^ rotl(x, 17);
    endfunction

    function automatic logic [WORD_W-1:0] perm1(input logic [WORD_W-1:0] x);
        return x ^ rotl(x, 15) ^ rotl(x, 23);
    endfunction

endpackage

// ===== sv/sm3_if.sv =====
interface sm3_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last;

    modport source (output valid, output data_word, output byte_count, output last,
                    input ready);
    modport sink   (input valid, input data_word, input byte_count, input last,
                    output ready);
endinterface

interface sm3_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output hash_word, output word_index, output last_word,
                    input ready);
    modport sink   (input valid, input hash_word, input word_index, input last_word,
                    output ready);
endinterface

// ===== sv/sm3_hash_engine_top.sv =====
// SM3 hash engine, 256-bit digest.
// Input channel i_in: one big-endian message word per transaction, with a
// byte count (leading valid bytes, used only on the last word) and a last mark.
// Output channel o_out: eight digest words per message, word_index 0 to 7,
// last_word set on the eighth.
// The front part pads the message tail (0x80 byte, zeros, 64-bit length) and
// feeds words into a four-entry queue; the back part collects 16-word blocks
// and runs the 64 rounds at one round per cycle.
// Throughput: the round unit sets it; the next block fills while rounds run.
// After the last word the front emits the padding words; each block is then
// loaded and runs its rounds, a second block following when the padding
// spills into it. The input is not taken while the front emits padding
// words.
// Reset: chain value returns to the initial vector, counters clear, the
// queue empties; no transactions are pending afterwards.
// Receiver stall: the digest word is held on o_out; the front and the block
// buffer keep taking words until the buffer and queue are full.
module sm3_hash_engine_top
    import sm3_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    sm3_in_if.sink    i_in,
    sm3_out_if.source o_out
);

    logic   push, full, q_valid, pop;
    t_qword push_data, q_data;

    sm3_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_push      (push),
        .o_push_data (push_data),
        .i_full      (full)
    );

    sm3_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (full),
        .o_valid     (q_valid),
        .o_data      (q_data),
        .i_pop       (pop)
    );

    sm3_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_data  (q_data),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

// ===== sv/sm3_queue.sv =====
module sm3_queue
    import sm3_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_qword i_push_data,
    output logic   o_full,
    output logic   o_valid,
    output t_qword o_data,
    input  logic   i_pop
);

    t_qword           r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr, r_rd;
    logic [QAW:0]     r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== sv/sm3_front.sv =====
module sm3_front
    import sm3_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    sm3_in_if.sink i_in,
    output logic   o_push,
    output t_qword o_push_data,
    input  logic   i_full
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_ZERO  = 3'd2;
    localparam logic [2:0] ST_LENLO = 3'd3;

    localparam logic [3:0] LEN_SLOT = 4'(BLOCK_WDS - 2);

    logic [2:0]       r_state, n_state;
    logic [3:0]       r_fill;
    logic [LEN_W-1:0] r_len, n_len;
    logic             accept;
    logic [2:0]       count;
    logic [WORD_W-1:0] first_word;

    assign i_in.ready = (r_state == ST_IDLE) && !i_full;
    assign accept     = i_in.valid && i_in.ready;

    // Clamp byte count and build the padded tail word
    always_comb begin
        count = (i_in.byte_count > BYTES_FULL) ? BYTES_FULL : i_in.byte_count;
        if (!i_in.last) begin
            count = BYTES_FULL;
        end
        case (count)
            3'd0:    first_word = PAD_WORD;
            3'd1:    first_word = {i_in.data_word[31:24], 24'h80_0000};
            3'd2:    first_word = {i_in.data_word[31:16], 16'h8000};
            3'd3:    first_word = {i_in.data_word[31:8], 8'h80};
            default: first_word = i_in.data_word;
        endcase
    end

    // Pick the word to push and the next state
    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        o_push      = 1'b0;
        o_push_data = '{word: '0, final_wd: 1'b0};
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_push           = 1'b1;
                    o_push_data.word = first_word;
                    n_len            = r_len + LEN_W'({count, 3'b000});
                    if (i_in.last) begin
                        n_state = (count == BYTES_FULL) ? ST_PAD : ST_ZERO;
                    end
                end
            end
            ST_PAD: begin
                o_push           = !i_full;
                o_push_data.word = PAD_WORD;
                if (!i_full) begin
                    n_state = ST_ZERO;
                end
            end
            ST_ZERO: begin
                o_push = !i_full;
                if (r_fill == LEN_SLOT) begin
                    o_push_data.word = r_len[LEN_W-1:WORD_W];
                    if (!i_full) begin
                        n_state = ST_LENLO;
                    end
                end
            end
            ST_LENLO: begin
                o_push               = !i_full;
                o_push_data.word     = r_len[WORD_W-1:0];
                o_push_data.final_wd = 1'b1;
                if (!i_full) begin
                    n_len   = '0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold state, fill position and bit length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_len   <= '0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            if (o_push && !i_full) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

endmodule

// ===== sv/sm3_back.sv =====
module sm3_back
    import sm3_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_qword     i_data,
    output logic       o_pop,
    sm3_out_if.source  o_out
);

    localparam logic [1:0] B_WAIT  = 2'd0;
    localparam logic [1:0] B_ROUND = 2'd1;
    localparam logic [1:0] B_OUT   = 2'd2;

    localparam int RW = $clog2(ROUNDS);
    localparam int BW = $clog2(BLOCK_WDS + 1);
    localparam int DW = $clog2(DIGEST_WDS);

    logic [1:0]        r_state;
    logic [WORD_W-1:0] r_buf   [BLOCK_WDS];
    logic [BW-1:0]     r_bcnt;
    logic              r_bfinal;
    logic [WORD_W-1:0] r_win   [BLOCK_WDS];
    logic [WORD_W-1:0] r_v     [DIGEST_WDS];
    logic [WORD_W-1:0] n_v     [DIGEST_WDS];
    logic [WORD_W-1:0] r_chain [DIGEST_WDS];
    logic [WORD_W-1:0] r_t;
    logic [RW-1:0]     r_rnd;
    logic              r_cfinal;
    logic [DW-1:0]     r_idx;

    logic              buf_full, start, out_fire, last_rnd;
    logic [WORD_W-1:0] a12, ss1, ss2, fj, gj, tt1, tt2, w_new;

    assign buf_full = (r_bcnt == BW'(BLOCK_WDS));
    assign o_pop    = !buf_full;
    assign start    = (r_state == B_WAIT) && buf_full;
    assign last_rnd = (r_rnd == RW'(ROUNDS - 1));

    assign o_out.valid      = (r_state == B_OUT);
    assign o_out.hash_word  = r_chain[r_idx];
    assign o_out.word_index = 3'(r_idx);
    assign o_out.last_word  = (r_idx == DW'(DIGEST_WDS - 1));
    assign out_fire         = o_out.valid && o_out.ready;

    // One compression round and one expanded word
    always_comb begin
        a12 = rotl(r_v[0], 12);
        ss1 = rotl(a12 + r_v[4] + r_t, 7);
        ss2 = ss1 ^ a12;
        if (r_rnd < RW'(16)) begin
            fj = r_v[0] ^ r_v[1] ^ r_v[2];
            gj = r_v[4] ^ r_v[5] ^ r_v[6];
        end else begin
            fj = (r_v[0] & r_v[1]) | (r_v[0] & r_v[2]) | (r_v[1] & r_v[2]);
            gj = (r_v[4] & r_v[5]) | (~r_v[4] & r_v[6]);
        end
        tt1 = fj + r_v[3] + ss2 + (r_win[0] ^ r_win[4]);
        tt2 = gj + r_v[7] + ss1 + r_win[0];
        n_v[0] = tt1;
        n_v[1] = r_v[0];
        n_v[2] = rotl(r_v[1], 9);
        n_v[3] = r_v[2];
        n_v[4] = perm0(tt2);
        n_v[5] = r_v[4];
        n_v[6] = rotl(r_v[5], 19);
        n_v[7] = r_v[6];
        w_new = perm1(r_win[0] ^ r_win[7] ^ rotl(r_win[13], 15))
                ^ rotl(r_win[3], 7) ^ r_win[10];
    end

    // Shift popped words into the block buffer
    always_ff @(posedge i_clk) begin
        if (o_pop && i_valid) begin
            for (int i = 0; i < BLOCK_WDS - 1; i++) begin
                r_buf[i] <= r_buf[i+1];
            end
            r_buf[BLOCK_WDS-1] <= i_data.word;
        end
    end

    // Load the window at start, then slide it each round
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_win <= r_buf;
            r_v   <= r_chain;
            r_t   <= T_LOW;
        end else if (r_state == B_ROUND) begin
            for (int i = 0; i < BLOCK_WDS - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[BLOCK_WDS-1] <= w_new;
            r_v <= n_v;
            r_t <= (r_rnd == RW'(15)) ? T_HIGH_ROT16 : rotl(r_t, 1);
        end
    end

    // Sequence buffer fill, rounds and digest output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_WAIT;
            r_bcnt   <= '0;
            r_bfinal <= 1'b0;
            r_cfinal <= 1'b0;
            r_rnd    <= '0;
            r_idx    <= '0;
            r_chain  <= SM3_IV;
        end else begin
            if (start) begin
                r_bcnt   <= '0;
                r_bfinal <= 1'b0;
            end else if (o_pop && i_valid) begin
                r_bcnt   <= r_bcnt + 1'b1;
                r_bfinal <= i_data.final_wd;
            end
            case (r_state)
                B_WAIT: begin
                    if (start) begin
                        r_cfinal <= r_bfinal;
                        r_rnd    <= '0;
                        r_state  <= B_ROUND;
                    end
                end
                B_ROUND: begin
                    r_rnd <= r_rnd + 1'b1;
                    if (last_rnd) begin
                        for (int i = 0; i < DIGEST_WDS; i++) begin
                            r_chain[i] <= r_chain[i] ^ n_v[i];
                        end
                        r_idx   <= '0;
                        r_state <= r_cfinal ? B_OUT : B_WAIT;
                    end
                end
                B_OUT: begin
                    if (out_fire) begin
                        r_idx <= r_idx + 1'b1;
                        if (o_out.last_word) begin
                            r_chain <= SM3_IV;
                            r_state <= B_WAIT;
                        end
                    end
                end
                default: begin
                    r_state <= B_WAIT;
                end
            endcase
        end
    end

endmodule

// ===== bench/sm3_digest_check_pkg.sv =====
package sm3_digest_check_pkg;

    // One digest word as it leaves the engine
    typedef struct packed {
        logic [31:0] hash_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_word_t;

    localparam logic [31:0] HASH_IV [8] = '{
        32'h7380_166f, 32'h4914_b2b9, 32'h1724_42d7, 32'hda8a_0600,
        32'ha96f_30bc, 32'h1631_38aa, 32'he38d_ee4d, 32'hb0fb_0e4e
    };
    localparam logic [31:0] ROUND_T_LO = 32'h79cc_4519;
    localparam logic [31:0] ROUND_T_HI = 32'h7a87_9d8a;
    localparam logic [31:0] PAD_OPEN   = 32'h8000_0000;
    localparam int unsigned FULL_BYTES = 4;
    localparam int unsigned LEN_SLOT   = 14;

    // Tracks the message state, predicts digests and checks them in order
    class sm3_digest_board;
        logic [31:0]  chain[8];
        logic [31:0]  blk[16];
        int unsigned  fill;
        logic [63:0]  bit_len;
        digest_word_t digest_q[$];
        int unsigned  mismatches;
        int unsigned  results_checked;

        function new();
            mismatches      = 0;
            results_checked = 0;
            restart();
        endfunction

        function void restart();
            chain   = HASH_IV;
            fill    = 0;
            bit_len = '0;
        endfunction

        static function logic [31:0] rot_left(logic [31:0] x, int unsigned n);
            n = n % 32;
            if (n == 0)
                return x;
            return (x << n) | (x >> (32 - n));
        endfunction

        static function logic [31:0] diffuse_p0(logic [31:0] x);
            return x ^ rot_left(x, 9) ^ rot_left(x, 17);
        endfunction

        static function logic [31:0] diffuse_p1(logic [31:0] x);
            return x ^ rot_left(x, 15) ^ rot_left(x, 23);
        endfunction

        // Expand the buffered block and run the 64 rounds into the chain value
        function void compress_block();
            logic [31:0] w[68];
            logic [31:0] wp[64];
            logic [31:0] r[8];
            logic [31:0] t, a12, ss1, ss2, tt1, tt2, ff, gg;
            for (int j = 0; j < 16; j++)
                w[j] = blk[j];
            for (int j = 16; j < 68; j++)
                w[j] = diffuse_p1(w[j-16] ^ w[j-9] ^ rot_left(w[j-3], 15))
                       ^ rot_left(w[j-13], 7) ^ w[j-6];
            for (int j = 0; j < 64; j++)
                wp[j] = w[j] ^ w[j+4];
            r = chain;
            for (int j = 0; j < 64; j++) begin
                t   = rot_left((j < 16) ? ROUND_T_LO : ROUND_T_HI, j);
                a12 = rot_left(r[0], 12);
                ss1 = rot_left(a12 + r[4] + t, 7);
                ss2 = ss1 ^ a12;
                if (j < 16) begin
                    ff = r[0] ^ r[1] ^ r[2];
                    gg = r[4] ^ r[5] ^ r[6];
                end else begin
                    ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
                    gg = (r[4] & r[5]) | (~r[4] & r[6]);
                end
                tt1  = ff + r[3] + ss2 + wp[j];
                tt2  = gg + r[7] + ss1 + w[j];
                r[3] = r[2];
                r[2] = rot_left(r[1], 9);
                r[1] = r[0];
                r[0] = tt1;
                r[7] = r[6];
                r[6] = rot_left(r[5], 19);
                r[5] = r[4];
                r[4] = diffuse_p0(tt2);
            end
            for (int j = 0; j < 8; j++)
                chain[j] ^= r[j];
        endfunction

        function void push_word(logic [31:0] w);
            blk[fill] = w;
            fill = (fill + 1) % 16;
            if (fill == 0)
                compress_block();
        endfunction

        // Fold one accepted message word in; on the last word queue the digest
        function void note_input(logic [31:0] w, logic [2:0] cnt, logic is_last);
            int unsigned  nbytes;
            logic [31:0]  kept;
            digest_word_t dw;
            if (!is_last) begin
                push_word(w);
                bit_len += 64'd32;
            end else begin
                nbytes = (cnt > FULL_BYTES) ? FULL_BYTES : cnt;
                bit_len += 64'(8 * nbytes);
                if (nbytes == FULL_BYTES) begin
                    push_word(w);
                    push_word(PAD_OPEN);
                end else begin
                    kept = (nbytes == 0) ? '0 : (w & (32'hffff_ffff << (32 - 8 * nbytes)));
                    push_word(kept | (32'h80 << (24 - 8 * nbytes)));
                end
                while (fill != LEN_SLOT)
                    push_word('0);
                push_word(bit_len[63:32]);
                push_word(bit_len[31:0]);
                for (int i = 0; i < 8; i++) begin
                    dw.hash_word  = chain[i];
                    dw.word_index = 3'(i);
                    dw.last_word  = (i == 7);
                    digest_q.push_back(dw);
                end
                restart();
            end
        endfunction

        task report(string msg);
            $display("[%0t] ERROR %s", $time, msg);
            mismatches++;
        endtask

        // Compare one accepted digest word against the oldest expectation
        task check_result(logic [31:0] h, logic [2:0] idx, logic lw);
            digest_word_t exp_w;
            results_checked++;
            if (digest_q.size() == 0) begin
                report($sformatf("digest word idx %0d = %08h with nothing expected", idx, h));
            end else begin
                exp_w = digest_q.pop_front();
                if (h !== exp_w.hash_word)
                    report($sformatf("hash_word idx %0d: got %08h, want %08h",
                                     exp_w.word_index, h, exp_w.hash_word));
                if (idx !== exp_w.word_index)
                    report($sformatf("word_index: got %0d, want %0d", idx, exp_w.word_index));
                if (lw !== exp_w.last_word)
                    report($sformatf("last_word idx %0d: got %0b, want %0b",
                                     exp_w.word_index, lw, exp_w.last_word));
            end
        endtask

        function int unsigned pending();
            return digest_q.size();
        endfunction
    endclass

endpackage

// ===== bench/sm3_hash_engine_top_tb.sv =====
module sm3_hash_engine_top_tb
    import sm3_digest_check_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ITEM_TARGET  = 430;
    localparam int unsigned STALL_LIMIT  = 5000;
    localparam int unsigned LONG_HOLD    = 600;
    localparam int unsigned HOLD_TRIGGER = 160;
    localparam int unsigned DRAIN_CYCLES = 120;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sm3_in_if  in_if ();
    sm3_out_if out_if ();

    sm3_hash_engine_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    sm3_digest_board digest_board = new();

    int unsigned items_sent;
    int unsigned burst_left;
    int unsigned idle_cycles;
    bit          long_hold_done;

    // Free-running clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Watch both channels: note accepted words, check digest words, count idle
    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready)
            digest_board.note_input(in_if.data_word, in_if.byte_count, in_if.last);
        if (i_rst_n && out_if.valid && out_if.ready)
            digest_board.check_result(out_if.hash_word, out_if.word_index, out_if.last_word);
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // End the run if nothing moves for too long
    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // Digest receiver: random stall patterns, plus one long hold-off
    initial begin
        int unsigned mode;
        int unsigned phase;
        phase = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(16, 96)) begin
                @(negedge i_clk);
                phase++;
                case (mode)
                    0: out_if.ready <= 1'b1;
                    1: out_if.ready <= ($urandom_range(0, 3) != 0);
                    2: out_if.ready <= ($urandom_range(0, 3) == 0);
                    default: out_if.ready <= ((phase % 5) < 2);
                endcase
            end
            if (!long_hold_done && digest_board.results_checked >= HOLD_TRIGGER) begin
                @(negedge i_clk);
                out_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                long_hold_done = 1'b1;
            end
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 15))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    // Offer one message word; open a new burst after a random gap
    task automatic send_item(logic [31:0] w, logic [2:0] cnt, logic is_last);
        @(negedge i_clk);
        if (burst_left == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        in_if.valid      <= 1'b1;
        in_if.data_word  <= w;
        in_if.byte_count <= cnt;
        in_if.last       <= is_last;
        do @(posedge i_clk); while (!in_if.ready);
        items_sent++;
    endtask

    // Drop valid and hold until every expected digest word has come back
    task automatic wait_for_digests();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        burst_left = 0;
        while (digest_board.pending() != 0) @(posedge i_clk);
    endtask

    task automatic send_random_message();
        int unsigned n_words;
        n_words = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
        for (int unsigned i = 1; i < n_words; i++)
            send_item(pick_word(), 3'($urandom_range(0, 7)), 1'b0);
        send_item(pick_word(), 3'($urandom_range(0, 7)), 1'b1);
    endtask

    // Reset, directed messages, random messages, drain and verdict
    initial begin
        bit paused_once;
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.data_word  = '0;
        in_if.byte_count = '0;
        in_if.last       = 1'b0;
        out_if.ready     = 1'b0;
        items_sent       = 0;
        burst_left       = 0;
        idle_cycles      = 0;
        long_hold_done   = 1'b0;
        paused_once      = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty message: a lone last word with no bytes
        send_item(32'hdead_beef, 3'd0, 1'b1);
        // Short tails of one to three bytes, the classic three-byte message, one full word
        send_item(32'h6162_6300, 3'd3, 1'b1);
        send_item(32'hffff_ffff, 3'd1, 1'b1);
        send_item(32'hffff_ffff, 3'd2, 1'b1);
        send_item(32'h0000_0000, 3'd4, 1'b1);
        // Byte counts above four on the last word count as four
        send_item(32'hffff_ffff, 3'd5, 1'b1);
        send_item(32'h1234_5678, 3'd6, 1'b1);
        send_item(32'hffff_ffff, 3'd7, 1'b1);
        // Byte count on a word that is not last is ignored
        send_item(32'ha5a5_5a5a, 3'd0, 1'b0);
        send_item(32'h0f0f_f0f0, 3'd4, 1'b1);
        // Fourteen words: padding spills into a second block
        for (int unsigned i = 0; i < 13; i++)
            send_item(pick_word(), 3'(i % 8), 1'b0);
        send_item(32'hffff_ffff, 3'd4, 1'b1);
        wait_for_digests();

        // Random messages, with one full pause partway through
        while (items_sent < ITEM_TARGET) begin
            if (!paused_once && items_sent >= 250) begin
                wait_for_digests();
                paused_once = 1'b1;
            end
            send_random_message();
        end

        wait_for_digests();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (digest_board.pending() != 0)
            digest_board.report($sformatf("%0d expected digest words never arrived",
                                          digest_board.pending()));
        if (digest_board.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
